### src/drpu_pkg.sv
package drpu_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS      = 8;
   localparam int MOVE_SHIFT     = 25 - FRAC_BITS;

   localparam int TIME_W     = 10;
   localparam int SPEED_W    = 16;
   localparam int RADIUS_W   = 10;
   localparam int POS_W      = 32;
   localparam int HEAD_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int MUL_A_W  = 27;
   localparam int MUL_B_W  = 31;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int MAG_W    = 55;
   localparam int MOVE_W   = 34;
   localparam int TRIG_W   = 16;
   localparam int CORDIC_W = 18;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W   = 5;

   localparam logic [RADIUS_W-1:0]       RADIUS_RESET  = 10'd105;
   localparam logic signed [MUL_B_W-1:0] INV_TWO_PI    = 31'sd683565276;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 18'sd19898;
   localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 18'sd16384;
   localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 18'sd32768;
   localparam logic signed [CORDIC_W-1:0] TRIG_MAX     = 18'sd32767;
   localparam logic signed [POS_W-1:0]   POS_MAX       = 32'sh7FFFFFFF;
   localparam logic signed [POS_W-1:0]   POS_MIN       = 32'sh80000000;
   localparam logic signed [PROD_W-1:0]  ROUND_HALF    = PROD_W'(1) << (MOVE_SHIFT - 1);

   localparam logic [CSR_IDX_W-1:0] REG_MOTION_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_RADIUS = 2'd2;

   localparam logic MODE_FORWARD = 1'b0;
   localparam logic MODE_TURN    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SDT,
      ST_BRANCH,
      ST_ABS,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_TURN,
      ST_TRIG_RUN,
      ST_MUL_X,
      ST_MUL_Y,
      ST_ADD_X,
      ST_ADD_Y,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } trig_type;

   function automatic logic [13:0] atan_unit(input logic [3:0] idx);
      logic [13:0] r;
      case (idx)
         4'd0:    r = 14'd8192;
         4'd1:    r = 14'd4836;
         4'd2:    r = 14'd2555;
         4'd3:    r = 14'd1297;
         4'd4:    r = 14'd651;
         4'd5:    r = 14'd326;
         4'd6:    r = 14'd163;
         4'd7:    r = 14'd81;
         4'd8:    r = 14'd41;
         4'd9:    r = 14'd20;
         4'd10:   r = 14'd10;
         4'd11:   r = 14'd5;
         4'd12:   r = 14'd3;
         4'd13:   r = 14'd1;
         4'd14:   r = 14'd1;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] clamp_trig(
      input logic signed [CORDIC_W-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > TRIG_MAX) begin
         r = TRIG_W'(TRIG_MAX);
      end else if (v < -TRIG_MAX) begin
         r = -TRIG_W'(TRIG_MAX);
      end else begin
         r = v[TRIG_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [MOVE_W-1:0] move_round(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + ROUND_HALF;
      t = t >>> MOVE_SHIFT;
      return t[MOVE_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] sat_add(
      input logic signed [POS_W-1:0] p,
      input logic signed [MOVE_W-1:0] d);
      logic signed [MOVE_W:0] s;
      logic signed [POS_W-1:0] r;
      s = (MOVE_W+1)'(p) + (MOVE_W+1)'(d);
      if (s > (MOVE_W+1)'(POS_MAX)) begin
         r = POS_MAX;
      end else if (s < (MOVE_W+1)'(POS_MIN)) begin
         r = POS_MIN;
      end else begin
         r = s[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

### src/dead_reckoning_pose_update.sv
// Pose tracker for a two-wheeled robot: every accepted request (one tick of
// time_step/1024 s) either turns the heading by speed*dt/turn_radius or moves
// x/y along the heading by speed*dt, then returns x, y (Q24.8 mm, saturating)
// and the 16-bit heading. One request is worked on at a time. A forward tick
// is paced by the 16-step shift-add sine/cosine unit and the three passes
// through the shared multiplier; a turn tick is paced by the bit-serial
// divider (one quotient bit per cycle). The finished pose sits in an output
// register, so the next request is taken while it waits. The user must write
// configuration only between requests; the block does not enforce this.
module dead_reckoning_pose_update #(
   parameter int ANGLE_BITS = drpu_pkg::ANGLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [drpu_pkg::TIME_W-1:0]           req_time_step,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [drpu_pkg::POS_W-1:0]     rsp_x_position,
   output logic signed [drpu_pkg::POS_W-1:0]     rsp_y_position,
   output logic [drpu_pkg::HEAD_W-1:0]           rsp_heading,
   input  logic                                  csr_write,
   input  logic [drpu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [drpu_pkg::CSR_DATA_W-1:0]       csr_data
);
   import drpu_pkg::*;

   localparam int DIV_SHIFT = 42 - ANGLE_BITS;
   localparam int DIVD_W    = ANGLE_BITS + 13;
   localparam int NUM_W     = MAG_W + 1;

   state_type state_ff, state_in;

   logic                       motion_ff;
   logic signed [SPEED_W-1:0]  speed_ff;
   logic [RADIUS_W-1:0]        radius_ff;

   logic [ANGLE_BITS-1:0]      heading_ff, heading_in;
   logic signed [POS_W-1:0]    pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]    pos_y_ff, pos_y_in;

   logic [TIME_W-1:0]          time_step_ff, time_step_in;
   logic signed [MUL_A_W-1:0]  sdt_ff, sdt_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic signed [MOVE_W-1:0]   dx_ff, dx_in;
   logic signed [MOVE_W-1:0]   dy_ff, dy_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]    rsp_x_ff, rsp_x_in;
   logic signed [POS_W-1:0]    rsp_y_ff, rsp_y_in;
   logic [HEAD_W-1:0]          rsp_head_ff, rsp_head_in;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   prod_neg;

   logic                       cordic_start;
   logic                       cordic_done;
   trig_type                   trig;

   logic                       div_start;
   logic                       div_done;
   logic [DIVD_W-1:0]          dividend;
   logic [ANGLE_BITS-1:0]      quotient;
   logic [RADIUS_W-1:0]        radius_eff;
   logic [NUM_W-1:0]           num_rounded;

   logic [HEAD_W-1:0]          heading16;
   logic                       req_fire;
   logic                       rsp_load;

   generate
      if (ANGLE_BITS >= HEAD_W) begin : g_head_top
         assign heading16 = heading_ff[ANGLE_BITS-1 -: HEAD_W];
      end else begin : g_head_pad
         assign heading16 = {heading_ff, {(HEAD_W-ANGLE_BITS){1'b0}}};
      end
   endgenerate

   drpu_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   drpu_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (heading16),
      .done  (cordic_done),
      .trig  (trig)
   );

   drpu_div #(
      .DIVD_W (DIVD_W),
      .QUOT_W (ANGLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (radius_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign prod_neg    = -prod;
   assign radius_eff  = (radius_ff == '0) ? RADIUS_W'(1) : radius_ff;
   assign num_rounded = {1'b0, mag_ff} + (NUM_W'(radius_eff) << (DIV_SHIFT - 1));
   assign dividend    = num_rounded[DIV_SHIFT +: DIVD_W];

   always_comb begin
      state_in     = state_ff;
      heading_in   = heading_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      time_step_in = time_step_ff;
      sdt_in       = sdt_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      mul_a        = sdt_ff;
      mul_b        = MUL_B_W'(trig.cos_val);
      cordic_start = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               time_step_in = req_time_step;
               state_in     = ST_MUL_SDT;
            end
         end
         ST_MUL_SDT: begin
            mul_a    = MUL_A_W'(speed_ff);
            mul_b    = signed'(MUL_B_W'(time_step_ff));
            state_in = ST_BRANCH;
         end
         ST_BRANCH: begin
            sdt_in = prod[MUL_A_W-1:0];
            if (motion_ff == MODE_TURN) begin
               mul_a    = prod[MUL_A_W-1:0];
               mul_b    = INV_TWO_PI;
               state_in = ST_ABS;
            end else begin
               cordic_start = 1'b1;
               state_in     = ST_TRIG_RUN;
            end
         end
         ST_ABS: begin
            neg_in   = prod[PROD_W-1];
            mag_in   = prod[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod[MAG_W-1:0];
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            heading_in = neg_ff ? heading_ff - quotient : heading_ff + quotient;
            state_in   = ST_DONE;
         end
         ST_TRIG_RUN: begin
            if (cordic_done) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            mul_b    = MUL_B_W'(trig.cos_val);
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            mul_b    = MUL_B_W'(trig.sin_val);
            dx_in    = move_round(prod);
            state_in = ST_ADD_X;
         end
         ST_ADD_X: begin
            pos_x_in = sat_add(pos_x_ff, dx_ff);
            dy_in    = move_round(prod);
            state_in = ST_ADD_Y;
         end
         ST_ADD_Y: begin
            pos_y_in = sat_add(pos_y_ff, dy_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_head_in = rsp_head_ff;
      if (rsp_load) begin
         rsp_x_in    = pos_x_ff;
         rsp_y_in    = pos_y_ff;
         rsp_head_in = heading16;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control, configuration and pose
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         motion_ff    <= MODE_FORWARD;
         speed_ff     <= '0;
         radius_ff    <= RADIUS_RESET;
         heading_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         heading_ff   <= heading_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         if (csr_write) begin
            case (csr_index)
               REG_MOTION_MODE: motion_ff <= csr_data[0];
               REG_SPEED:       speed_ff  <= signed'(csr_data[SPEED_W-1:0]);
               REG_TURN_RADIUS: radius_ff <= csr_data[RADIUS_W-1:0];
               default:         ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      time_step_ff <= time_step_in;
      sdt_ff       <= sdt_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_head_ff  <= rsp_head_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_position = rsp_x_ff;
   assign rsp_y_position = rsp_y_ff;
   assign rsp_heading    = rsp_head_ff;

endmodule

### src/drpu_mul.sv
module drpu_mul (
   input  logic                                 clock,
   input  logic signed [drpu_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [drpu_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [drpu_pkg::PROD_W-1:0]   prod
);
   import drpu_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### src/drpu_cordic.sv
module drpu_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [drpu_pkg::HEAD_W-1:0]    angle,
   output logic                           done,
   output drpu_pkg::trig_type             trig
);
   import drpu_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic                       flip_ff, flip_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   trig_type                   trig_ff, trig_in;

   logic signed [CORDIC_W-1:0] ang;
   logic signed [CORDIC_W-1:0] ang_fold;
   logic                       ang_flip;
   logic signed [CORDIC_W-1:0] xs, ys, atan_v;
   logic signed [TRIG_W-1:0]   c_cl, s_cl;

   always_comb begin
      ang = CORDIC_W'(signed'(angle));
      ang_fold = ang;
      ang_flip = 1'b0;
      if (ang > QUARTER_TURN) begin
         ang_fold = ang - HALF_TURN;
         ang_flip = 1'b1;
      end else if (ang < -QUARTER_TURN) begin
         ang_fold = ang + HALF_TURN;
         ang_flip = 1'b1;
      end
   end

   assign xs     = x_ff >>> step_ff[3:0];
   assign ys     = y_ff >>> step_ff[3:0];
   assign atan_v = signed'(CORDIC_W'(atan_unit(step_ff[3:0])));
   assign c_cl   = clamp_trig(x_ff);
   assign s_cl   = clamp_trig(y_ff);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trig_in = trig_ff;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = ang_fold;
         flip_in = ang_flip;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff < STEP_W'(CORDIC_STEPS)) begin
            if (!z_ff[CORDIC_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_v;
            end
            step_in = step_ff + STEP_W'(1);
         end else begin
            trig_in.cos_val = flip_ff ? -c_cl : c_cl;
            trig_in.sin_val = flip_ff ? -s_cl : s_cl;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      trig_ff <= trig_in;
   end

   assign done = done_ff;
   assign trig = trig_ff;

endmodule

### src/drpu_div.sv
module drpu_div #(
   parameter int DIVD_W = 29,
   parameter int QUOT_W = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DIVD_W-1:0]                 dividend,
   input  logic [drpu_pkg::RADIUS_W-1:0]     divisor,
   output logic                              done,
   output logic [QUOT_W-1:0]                 quotient
);
   import drpu_pkg::*;

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic [DIVD_W-1:0]   dvd_ff, dvd_in;
   logic [RADIUS_W-1:0] rem_ff, rem_in;
   logic [RADIUS_W-1:0] dsr_ff, dsr_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [RADIUS_W:0]   shifted;
   logic [RADIUS_W+1:0] trial;
   logic                fits;

   assign shifted = {rem_ff, dvd_ff[DIVD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};
   assign fits    = !trial[RADIUS_W+1];

   always_comb begin
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         dvd_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = CNT_W'(DIVD_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[RADIUS_W-1:0] : shifted[RADIUS_W-1:0];
         quot_in  = {quot_ff[QUOT_W-2:0], fits};
         dvd_in   = {dvd_ff[DIVD_W-2:0], 1'b0};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### src/drpu_checker.sv
module drpu_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [drpu_pkg::POS_W-1:0]     rsp_x_position,
   input logic signed [drpu_pkg::POS_W-1:0]     rsp_y_position,
   input logic [drpu_pkg::HEAD_W-1:0]           rsp_heading
);

   // a waiting pose holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_position)
         && $stable(rsp_y_position) && $stable(rsp_heading))
      else $error("pose changed while stalled");

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind dead_reckoning_pose_update drpu_checker u_drpu_checker (.*);
